// ===== hdl/psseq_pkg.sv =====
// Shared types, constants and codes of the pattern step sequencer.
package psseq_pkg;

   localparam int PATTERNS = 8;
   localparam int STEPS    = 16;
   localparam int PAT_W    = 3;
   localparam int STEP_W   = 4;
   localparam int SLOT_W   = PAT_W + STEP_W;
   localparam int SLOTS    = PATTERNS * STEPS;
   localparam int EVENT_W  = 16;
   localparam int FRAME_W  = 13;
   localparam int PERIOD_W = 24;
   localparam int ACC_W    = 25;
   localparam int CNT_W    = 32;
   localparam int MOD_W    = 8;
   localparam int DIV_CNT_W = 5;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd5513;
   localparam logic [MOD_W-1:0]    MOD_RESET    = 8'd4;
   localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};

   localparam logic [2:0] CMD_TICK          = 3'd0;
   localparam logic [2:0] CMD_RUN_STATE     = 3'd1;
   localparam logic [2:0] CMD_SET_SLOT      = 3'd2;
   localparam logic [2:0] CMD_SET_MUTE      = 3'd3;
   localparam logic [2:0] CMD_SET_MODULO    = 3'd4;
   localparam logic [2:0] CMD_RESET_PATTERN = 3'd5;

   localparam logic [EVENT_W-1:0] OP_STOP   = 16'd0;
   localparam logic [EVENT_W-1:0] OP_START  = 16'd1;
   localparam logic [EVENT_W-1:0] OP_PAUSE  = 16'd2;
   localparam logic [EVENT_W-1:0] OP_RESUME = 16'd3;

   typedef enum logic [1:0] {
      RUN_STOPPED = 2'd0,
      RUN_RUNNING = 2'd1,
      RUN_PAUSED  = 2'd2
   } run_state_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_CHECK,
      SEQ_DIVIDE,
      SEQ_READ_CUR,
      SEQ_READ_NEXT,
      SEQ_EVAL,
      SEQ_PUSH,
      SEQ_ADVANCE,
      SEQ_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic [2:0]          command;
      logic [PAT_W-1:0]    pattern;
      logic [STEP_W-1:0]   step;
      logic [EVENT_W-1:0]  value;
      logic                all_patterns;
      logic [FRAME_W-1:0]  sample_count;
   } req_type;

   typedef struct packed {
      logic [PAT_W-1:0]    trigger_pattern;
      logic [STEP_W-1:0]   trigger_step;
      logic [EVENT_W-1:0]  event_code;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                event_en;
      logic                mute_en;
      logic                clear_en;
      logic [PAT_W-1:0]    pattern;
      logic [STEP_W-1:0]   step;
      logic [EVENT_W-1:0]  event_code;
      logic                mute;
   } slot_write_type;

   typedef struct packed {
      logic                done;
      logic                rem_zero;
   } div_status_type;

endpackage

// ===== hdl/psseq_slot_mem.sv =====
// Slot store: event codes and mute flags of every pattern step, with per-entry valid bits.
module psseq_slot_mem (
   input  logic                                 clock,
   input  logic                                 reset,
   input  psseq_pkg::slot_write_type            wr,
   input  logic                                 rd_en,
   input  logic [psseq_pkg::SLOT_W-1:0]         rd_addr,
   output logic [psseq_pkg::EVENT_W-1:0]        rd_event,
   output logic                                 rd_mute
);

   logic [psseq_pkg::EVENT_W-1:0] event_mem [psseq_pkg::SLOTS];
   logic                          mute_mem  [psseq_pkg::SLOTS];
   logic [psseq_pkg::SLOTS-1:0]   event_vld_ff;
   logic [psseq_pkg::SLOTS-1:0]   mute_vld_ff;
   logic [psseq_pkg::EVENT_W-1:0] event_q_ff;
   logic                          mute_q_ff;
   logic                          event_v_ff;
   logic                          mute_v_ff;
   logic [psseq_pkg::SLOT_W-1:0]  wr_addr;

   assign wr_addr = {wr.pattern, wr.step};

   always_ff @(posedge clock) begin
      if (wr.event_en) begin
         event_mem[wr_addr] <= wr.event_code;
      end
      if (wr.mute_en) begin
         mute_mem[wr_addr] <= wr.mute;
      end
      if (rd_en) begin
         event_q_ff <= event_mem[rd_addr];
         mute_q_ff  <= mute_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_vld_ff <= '0;
         mute_vld_ff  <= '0;
         event_v_ff   <= 1'b0;
         mute_v_ff    <= 1'b0;
      end else begin
         if (rd_en) begin
            event_v_ff <= event_vld_ff[rd_addr];
            mute_v_ff  <= mute_vld_ff[rd_addr];
         end
         for (int i = 0; i < psseq_pkg::SLOTS; i++) begin
            if (wr.clear_en && (i / psseq_pkg::STEPS) == int'(wr.pattern)) begin
               event_vld_ff[i] <= 1'b0;
               mute_vld_ff[i]  <= 1'b0;
            end
         end
         if (wr.event_en) begin
            event_vld_ff[wr_addr] <= 1'b1;
         end
         if (wr.mute_en) begin
            mute_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_event = event_v_ff ? event_q_ff : '0;
   assign rd_mute  = mute_v_ff & mute_q_ff;

endmodule

// ===== hdl/psseq_mod_unit.sv =====
// Bit-serial remainder unit for the step counter divider check.
module psseq_mod_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [psseq_pkg::CNT_W-1:0]      dividend,
   input  logic [psseq_pkg::MOD_W-1:0]      divisor,
   output psseq_pkg::div_status_type        status
);

   logic                             busy_ff;
   logic                             done_ff;
   logic [psseq_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [psseq_pkg::CNT_W-1:0]      num_ff;
   logic [psseq_pkg::MOD_W-1:0]      div_ff;
   logic [psseq_pkg::MOD_W-1:0]      rem_ff;
   logic [psseq_pkg::MOD_W:0]        trial;
   logic [psseq_pkg::MOD_W-1:0]      rem_in;

   always_comb begin
      trial = {rem_ff, num_ff[psseq_pkg::CNT_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = psseq_pkg::MOD_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[psseq_pkg::MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == psseq_pkg::DIV_CNT_W'(psseq_pkg::CNT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[psseq_pkg::CNT_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

// ===== hdl/pattern_step_sequencer_unit.sv =====
// Top level of the pattern step sequencer: command decode, tick walk and result buffering.
// Commands other than a tick, and a tick that does not complete a step period, are handled
// in the idle state; a tick that does complete one walks the patterns in order: a stopped
// or paused pattern is checked and skipped, a running one with a modulo of 0 or 1 reads its
// current and next slots, and one with a divider first runs the bit-serial remainder over
// the 32-bit step counter and reads its slots only on a zero remainder. Each fired step
// yields one beat; a beat waits in a one-deep holding register until the next fire or the
// end of the walk sets its last flag, and the walk stalls while the output register is
// occupied.
module pattern_step_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  psseq_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output psseq_pkg::rsp_type                rsp_data,
   input  logic                              csr_write,
   input  logic [psseq_pkg::PERIOD_W-1:0]    csr_wdata
);

   psseq_pkg::seq_state_type      state_ff, state_in;
   logic [psseq_pkg::PERIOD_W-1:0] period_ff;
   logic [psseq_pkg::ACC_W-1:0]    acc_ff;
   psseq_pkg::run_state_type       run_ff [psseq_pkg::PATTERNS];
   logic [psseq_pkg::STEP_W-1:0]   ptr_ff [psseq_pkg::PATTERNS];
   logic [psseq_pkg::CNT_W-1:0]    cnt_ff [psseq_pkg::PATTERNS];
   logic [psseq_pkg::MOD_W-1:0]    mod_ff [psseq_pkg::PATTERNS];
   logic [psseq_pkg::PAT_W-1:0]    pat_ff;
   logic [psseq_pkg::STEP_W-1:0]   sp_ff;
   logic [psseq_pkg::EVENT_W-1:0]  cur_event_ff;
   logic                           cur_mute_ff;
   psseq_pkg::rsp_type             cand_ff;
   psseq_pkg::rsp_type             pend_ff;
   logic                           pend_valid_ff;
   psseq_pkg::rsp_type             rsp_ff;
   logic                           rsp_valid_ff;

   logic                           accept;
   logic                           out_free;
   logic                           rsp_load;
   logic                           fire;
   logic                           last_step;
   logic                           divided;
   logic [psseq_pkg::PERIOD_W-1:0] period;
   logic [psseq_pkg::ACC_W:0]      sum_wide;
   logic [psseq_pkg::ACC_W-1:0]    sum;
   logic                           step_due;
   logic [psseq_pkg::MOD_W-1:0]    mod_value;

   psseq_pkg::slot_write_type      slot_wr;
   logic                           rd_en;
   logic [psseq_pkg::SLOT_W-1:0]   rd_addr;
   logic [psseq_pkg::EVENT_W-1:0]  rd_event;
   logic                           rd_mute;
   logic                           div_start;
   psseq_pkg::div_status_type      div_status;

   psseq_slot_mem u_slot_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (slot_wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_event (rd_event),
      .rd_mute  (rd_mute)
   );

   psseq_mod_unit u_mod_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cnt_ff[pat_ff]),
      .divisor  (mod_ff[pat_ff]),
      .status   (div_status)
   );

   assign req_stall = (state_ff != psseq_pkg::SEQ_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && ((state_ff == psseq_pkg::SEQ_PUSH)
                                   || (state_ff == psseq_pkg::SEQ_FLUSH && pend_valid_ff));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign period    = (period_ff == '0) ? psseq_pkg::PERIOD_W'(1) : period_ff;
   assign sum_wide  = {1'b0, acc_ff} + (psseq_pkg::ACC_W + 1)'(req_data.sample_count);
   assign sum       = sum_wide[psseq_pkg::ACC_W] ? psseq_pkg::ACC_MAX
                                                 : sum_wide[psseq_pkg::ACC_W-1:0];
   assign step_due  = (sum >= psseq_pkg::ACC_W'(period));
   assign mod_value = (req_data.value > 16'd255) ? 8'd255 : req_data.value[7:0];

   assign fire      = (cur_event_ff != '0) && !cur_mute_ff;
   assign last_step = (sp_ff == psseq_pkg::STEP_W'(psseq_pkg::STEPS - 1));
   assign divided   = (mod_ff[pat_ff] > 8'd1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psseq_pkg::SEQ_IDLE: begin
            if (accept && req_data.command == psseq_pkg::CMD_TICK && step_due) begin
               state_in = psseq_pkg::SEQ_CHECK;
            end
         end
         psseq_pkg::SEQ_CHECK: begin
            if (run_ff[pat_ff] != psseq_pkg::RUN_RUNNING) begin
               state_in = psseq_pkg::SEQ_ADVANCE;
            end else if (divided) begin
               state_in = psseq_pkg::SEQ_DIVIDE;
            end else begin
               state_in = psseq_pkg::SEQ_READ_CUR;
            end
         end
         psseq_pkg::SEQ_DIVIDE: begin
            if (div_status.done) begin
               state_in = div_status.rem_zero ? psseq_pkg::SEQ_READ_CUR
                                              : psseq_pkg::SEQ_ADVANCE;
            end
         end
         psseq_pkg::SEQ_READ_CUR:  state_in = psseq_pkg::SEQ_READ_NEXT;
         psseq_pkg::SEQ_READ_NEXT: state_in = psseq_pkg::SEQ_EVAL;
         psseq_pkg::SEQ_EVAL: begin
            state_in = (fire && pend_valid_ff) ? psseq_pkg::SEQ_PUSH
                                               : psseq_pkg::SEQ_ADVANCE;
         end
         psseq_pkg::SEQ_PUSH: begin
            if (out_free) begin
               state_in = psseq_pkg::SEQ_ADVANCE;
            end
         end
         psseq_pkg::SEQ_ADVANCE: begin
            state_in = (pat_ff == psseq_pkg::PAT_W'(psseq_pkg::PATTERNS - 1))
                       ? psseq_pkg::SEQ_FLUSH : psseq_pkg::SEQ_CHECK;
         end
         psseq_pkg::SEQ_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = psseq_pkg::SEQ_IDLE;
            end
         end
         default: state_in = psseq_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      slot_wr            = '0;
      slot_wr.pattern    = req_data.pattern;
      slot_wr.step       = req_data.step;
      slot_wr.event_code = req_data.value;
      slot_wr.mute       = (req_data.value != '0);
      rd_en              = 1'b0;
      rd_addr            = {pat_ff, ptr_ff[pat_ff]};
      div_start          = 1'b0;
      unique case (state_ff)
         psseq_pkg::SEQ_IDLE: begin
            if (accept) begin
               slot_wr.event_en = (req_data.command == psseq_pkg::CMD_SET_SLOT);
               slot_wr.mute_en  = (req_data.command == psseq_pkg::CMD_SET_MUTE);
               slot_wr.clear_en = (req_data.command == psseq_pkg::CMD_RESET_PATTERN);
            end
         end
         psseq_pkg::SEQ_CHECK: begin
            div_start = (run_ff[pat_ff] == psseq_pkg::RUN_RUNNING) && divided;
         end
         psseq_pkg::SEQ_READ_CUR: begin
            rd_en = 1'b1;
         end
         psseq_pkg::SEQ_READ_NEXT: begin
            rd_en   = !last_step;
            rd_addr = {pat_ff, sp_ff + 1'b1};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= psseq_pkg::SEQ_IDLE;
         period_ff     <= psseq_pkg::PERIOD_RESET;
         acc_ff        <= '0;
         pat_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int p = 0; p < psseq_pkg::PATTERNS; p++) begin
            run_ff[p] <= psseq_pkg::RUN_STOPPED;
            ptr_ff[p] <= '0;
            cnt_ff[p] <= '0;
            mod_ff[p] <= psseq_pkg::MOD_RESET;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            period_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            psseq_pkg::SEQ_IDLE: begin
               pat_ff <= '0;
               if (accept) begin
                  unique case (req_data.command)
                     psseq_pkg::CMD_TICK: begin
                        acc_ff <= step_due ? sum - psseq_pkg::ACC_W'(period) : sum;
                     end
                     psseq_pkg::CMD_RUN_STATE: begin
                        for (int p = 0; p < psseq_pkg::PATTERNS; p++) begin
                           if (req_data.all_patterns
                               || req_data.pattern == psseq_pkg::PAT_W'(p)) begin
                              priority if (req_data.value == psseq_pkg::OP_STOP) begin
                                 run_ff[p] <= psseq_pkg::RUN_STOPPED;
                                 ptr_ff[p] <= '0;
                              end else if (req_data.value == psseq_pkg::OP_START) begin
                                 run_ff[p] <= psseq_pkg::RUN_RUNNING;
                                 ptr_ff[p] <= '0;
                              end else if (req_data.value == psseq_pkg::OP_PAUSE) begin
                                 run_ff[p] <= psseq_pkg::RUN_PAUSED;
                              end else if (req_data.value == psseq_pkg::OP_RESUME) begin
                                 run_ff[p] <= psseq_pkg::RUN_RUNNING;
                              end else begin
                              end
                           end
                        end
                     end
                     psseq_pkg::CMD_SET_MODULO: begin
                        mod_ff[req_data.pattern] <= mod_value;
                     end
                     psseq_pkg::CMD_RESET_PATTERN: begin
                        run_ff[req_data.pattern] <= psseq_pkg::RUN_STOPPED;
                        ptr_ff[req_data.pattern] <= '0;
                        cnt_ff[req_data.pattern] <= '0;
                        mod_ff[req_data.pattern] <= psseq_pkg::MOD_RESET;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            psseq_pkg::SEQ_DIVIDE: begin
               if (div_status.done && !div_status.rem_zero) begin
                  cnt_ff[pat_ff] <= cnt_ff[pat_ff] + 1'b1;
               end
            end
            psseq_pkg::SEQ_READ_CUR: begin
               cnt_ff[pat_ff] <= cnt_ff[pat_ff] + 1'b1;
               sp_ff          <= ptr_ff[pat_ff];
            end
            psseq_pkg::SEQ_READ_NEXT: begin
               cur_event_ff <= rd_event;
               cur_mute_ff  <= rd_mute;
            end
            psseq_pkg::SEQ_EVAL: begin
               cand_ff <= {pat_ff, sp_ff, cur_event_ff, 1'b0};
               if (fire && !pend_valid_ff) begin
                  pend_ff       <= {pat_ff, sp_ff, cur_event_ff, 1'b0};
                  pend_valid_ff <= 1'b1;
               end
               if (last_step || rd_event == '0) begin
                  ptr_ff[pat_ff] <= '0;
               end else begin
                  ptr_ff[pat_ff] <= sp_ff + 1'b1;
               end
            end
            psseq_pkg::SEQ_PUSH: begin
               if (out_free) begin
                  rsp_ff  <= pend_ff;
                  pend_ff <= cand_ff;
               end
            end
            psseq_pkg::SEQ_ADVANCE: begin
               pat_ff <= pat_ff + 1'b1;
            end
            psseq_pkg::SEQ_FLUSH: begin
               if (pend_valid_ff && out_free) begin
                  rsp_ff        <= {pend_ff.trigger_pattern, pend_ff.trigger_step,
                                    pend_ff.event_code, 1'b1};
                  pend_valid_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
